// ===== hdl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Holds the request and result structs and the controller/datapath command set.
// Depends on nothing; every other file in hdl/ imports it.
package ole_pkg;

    // Default number of entries in the list store.
    localparam int CAPACITY_DEF = 128;

    // Request modes.
    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_ERASE  = 3'd2;
    localparam logic [2:0] MODE_FIND   = 3'd3;
    localparam logic [2:0] MODE_APPEND = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADPOS  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_request;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         found_position;
        logic signed [31:0] removed_value;
        logic [7:0]         list_length;
    } t_result;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_TAIL,
        OP_UP,
        OP_PLACE,
        OP_POS,
        OP_GRAB,
        OP_DOWN,
        OP_SHRINK,
        OP_SCAN0,
        OP_SCAN,
        OP_APPEND
    } t_dp_op;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_dp_op     op;
        logic       reply;
        logic [2:0] status;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [2:0] mode;
        logic       ins_bad;
        logic       era_bad;
        logic       full;
        logic       empty;
        logic       ins_end;
        logic       up_last;
        logic       grab_last;
        logic       down_last;
        logic       hit;
        logic       scan_last;
    } t_dp_flags;

endpackage

// ===== hdl/ole_ctrl.sv =====
// Controller state machine of the ordered list engine.
// Sequences each request into datapath operations and decides the result status.
// Depends on ole_pkg.
module ole_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ole_pkg::t_dp_flags i_flags,
    output logic               o_busy,
    output ole_pkg::t_dp_cmd   o_cmd
);
    import ole_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECIDE    = 9'b000000010,
        S_INS_UP    = 9'b000000100,
        S_INS_PLACE = 9'b000001000,
        S_ERA_GRAB  = 9'b000010000,
        S_ERA_DOWN  = 9'b000100000,
        S_ERA_DROP  = 9'b001000000,
        S_SCAN      = 9'b010000000,
        S_MISS      = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_busy = (r_state != S_IDLE);

    // Next state and command for the current step of the request.
    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.reply  = 1'b0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                case (i_flags.mode)
                    MODE_CLEAR: begin
                        o_cmd.op    = OP_CLEAR;
                        o_cmd.reply = 1'b1;
                    end
                    MODE_INSERT: begin
                        if (i_flags.ins_bad) begin
                            o_cmd.reply  = 1'b1;
                            o_cmd.status = ST_BADPOS;
                        end else if (i_flags.full) begin
                            o_cmd.reply  = 1'b1;
                            o_cmd.status = ST_FULL;
                        end else if (i_flags.ins_end) begin
                            o_cmd.op    = OP_PLACE;
                            o_cmd.reply = 1'b1;
                        end else begin
                            o_cmd.op = OP_TAIL;
                            n_state  = S_INS_UP;
                        end
                    end
                    MODE_ERASE: begin
                        if (i_flags.era_bad) begin
                            o_cmd.reply  = 1'b1;
                            o_cmd.status = ST_BADPOS;
                        end else begin
                            o_cmd.op = OP_POS;
                            n_state  = S_ERA_GRAB;
                        end
                    end
                    MODE_FIND, MODE_APPEND: begin
                        if (i_flags.empty) begin
                            n_state = S_MISS;
                        end else begin
                            o_cmd.op = OP_SCAN0;
                            n_state  = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.reply = 1'b1;
                    end
                endcase
            end
            S_INS_UP: begin
                o_cmd.op = OP_UP;
                if (i_flags.up_last) begin
                    n_state = S_INS_PLACE;
                end
            end
            S_INS_PLACE: begin
                o_cmd.op    = OP_PLACE;
                o_cmd.reply = 1'b1;
                n_state     = S_IDLE;
            end
            S_ERA_GRAB: begin
                o_cmd.op = OP_GRAB;
                n_state  = i_flags.grab_last ? S_ERA_DROP : S_ERA_DOWN;
            end
            S_ERA_DOWN: begin
                o_cmd.op = OP_DOWN;
                if (i_flags.down_last) begin
                    n_state = S_ERA_DROP;
                end
            end
            S_ERA_DROP: begin
                o_cmd.op    = OP_SHRINK;
                o_cmd.reply = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_flags.hit) begin
                    o_cmd.reply  = 1'b1;
                    o_cmd.status = (i_flags.mode == MODE_FIND) ? ST_OK : ST_PRESENT;
                    n_state      = S_IDLE;
                end else if (i_flags.scan_last) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                o_cmd.reply = 1'b1;
                n_state     = S_IDLE;
                if (i_flags.mode == MODE_FIND) begin
                    o_cmd.status = ST_MISSING;
                end else if (i_flags.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.op = OP_APPEND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted request always starts with the decision step.
    a_start_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> r_state == S_DECIDE)
        else $error("request accepted without entering the decision step");

    // Every reply ends the request.
    a_reply_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.reply |=> r_state == S_IDLE)
        else $error("controller did not return to idle after a reply");

    // A bad position is only reported before any store access.
    a_badpos_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.reply && o_cmd.status == ST_BADPOS) |-> r_state == S_DECIDE)
        else $error("bad position reported after the list was touched");

endmodule

// ===== hdl/ole_datapath.sv =====
// Datapath of the ordered list engine: entry memory, length count, walk index
// and result register. Executes one controller operation per cycle.
// Depends on ole_pkg.
module ole_datapath #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ole_pkg::t_request  i_request,
    input  ole_pkg::t_dp_cmd   i_cmd,
    output ole_pkg::t_dp_flags o_flags,
    output logic               o_done,
    output ole_pkg::t_result   o_result
);
    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    logic [31:0]        r_mem [CAPACITY];
    logic [2:0]         r_mode;
    logic [7:0]         r_pos;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      n_idx;
    logic signed [31:0] r_rdata;
    logic [7:0]         r_where;
    logic [7:0]         n_where;
    logic signed [31:0] r_removed;
    logic signed [31:0] n_removed;
    logic               r_done;
    t_result            r_result;

    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [XW-1:0]      x_pos;
    logic [XW-1:0]      x_count;
    logic [XW-1:0]      x_idx;

    assign x_pos   = XW'(r_pos);
    assign x_count = XW'(r_count);
    assign x_idx   = XW'(r_idx);

    // Status toward the controller.
    assign o_flags.mode      = r_mode;
    assign o_flags.ins_bad   = (x_pos == '0) || (x_pos > x_count + 1'b1);
    assign o_flags.era_bad   = (x_pos == '0) || (x_pos > x_count);
    assign o_flags.full      = (r_count >= CW'(CAPACITY));
    assign o_flags.empty     = (r_count == '0);
    assign o_flags.ins_end   = (x_pos == x_count + 1'b1);
    assign o_flags.up_last   = (x_idx == x_pos);
    assign o_flags.grab_last = (x_idx + XW'(1) >= x_count);
    assign o_flags.down_last = (x_idx + XW'(2) >= x_count);
    assign o_flags.hit       = (r_rdata == r_value);
    assign o_flags.scan_last = (x_idx + XW'(1) >= x_count);

    // Operation decode: memory addresses and next values of the working registers.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_where   = r_where;
        n_removed = r_removed;
        rd_addr   = AW'(r_idx);
        wr_en     = 1'b0;
        wr_addr   = AW'(r_idx);
        wr_data   = r_rdata;
        case (i_cmd.op)
            OP_LOAD: begin
                n_where   = '0;
                n_removed = '0;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_TAIL: begin
                n_idx   = r_count;
                rd_addr = AW'(r_count - 1'b1);
            end
            OP_UP: begin
                wr_en   = 1'b1;
                rd_addr = AW'(r_idx - CW'(2));
                n_idx   = r_idx - 1'b1;
            end
            OP_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = AW'(x_pos - 1'b1);
                wr_data = r_value;
                n_count = r_count + 1'b1;
            end
            OP_POS: begin
                n_idx   = CW'(x_pos - 1'b1);
                rd_addr = AW'(x_pos - 1'b1);
            end
            OP_GRAB: begin
                n_removed = r_rdata;
                rd_addr   = AW'(r_idx + 1'b1);
            end
            OP_DOWN: begin
                wr_en   = 1'b1;
                rd_addr = AW'(r_idx + CW'(2));
                n_idx   = r_idx + 1'b1;
            end
            OP_SHRINK: begin
                n_count = r_count - 1'b1;
            end
            OP_SCAN0: begin
                n_idx   = '0;
                rd_addr = '0;
            end
            OP_SCAN: begin
                if (r_rdata == r_value) begin
                    n_where = 8'(r_idx + 1'b1);
                end
                n_idx   = r_idx + 1'b1;
                rd_addr = AW'(r_idx + 1'b1);
            end
            OP_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_count);
                wr_data = r_value;
                n_count = r_count + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Length count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.reply;
        end
    end

    // Request fields, walk index and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_mode  <= i_request.mode;
            r_pos   <= i_request.position;
            r_value <= i_request.value;
        end
        r_idx     <= n_idx;
        r_where   <= n_where;
        r_removed <= n_removed;
        if (i_cmd.reply) begin
            r_result.status         <= i_cmd.status;
            r_result.found_position <= n_where;
            r_result.removed_value  <= n_removed;
            r_result.list_length    <= 8'(n_count);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // The length never passes the store size.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length exceeds capacity");

    // Writes never land past the end of the list.
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> XW'(wr_addr) <= x_count)
        else $error("entry written beyond the list end");

    // A reported length matches the count left behind.
    a_len_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_result.list_length == 8'(r_count))
        else $error("reported length differs from the stored count");

endmodule

// ===== hdl/ordered_list_engine_top.sv =====
// Top level of the ordered list engine: an array list of signed 32-bit values.
// Joins the controller (ole_ctrl) and the datapath (ole_datapath); uses ole_pkg.
//
//   Port       | Dir | Carries
//   -----------+-----+------------------------------------------------------
//   start      | in  | request strobe, taken when busy is low
//   i_request  | in  | mode, position, value
//   busy       | out | high from the accepting edge until the result strobe
//   o_done     | out | result strobe, one cycle
//   o_result   | out | status, found_position, removed_value, list_length
//
// Request duration depends on mode, position and list length. The bound is the entry
// memory, with one read and one write port, which moves or compares one entry
// per cycle.
// Reset is synchronous and empties the list; no clearing pass is needed.
// busy falls in the cycle of the result strobe; results cannot be held off.
module ordered_list_engine_top #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ole_pkg::t_request i_request,
    output logic              busy,
    output logic              o_done,
    output ole_pkg::t_result  o_result
);
    import ole_pkg::*;

    t_dp_cmd   dp_cmd;
    t_dp_flags dp_flags;

    // Sequencer.
    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (dp_flags),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    // Store, count and result register.
    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (dp_cmd),
        .o_flags   (dp_flags),
        .o_done    (o_done),
        .o_result  (o_result)
    );

endmodule
